### src/bpy_pkg.sv
// ----------------------------------------------------------------------------
// bpy_pkg
// Shared types, coefficient sets and rounding helpers for the premultiplied
// BGRA to limited-range YCbCr converter.
// ----------------------------------------------------------------------------
`default_nettype none

package bpy_pkg;

  // Input request payload.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       chroma_site;
  } in_t;

  // Result payload.
  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb;
    logic [7:0] cr;
  } out_t;

  // Premultiplied pixel handed from the premultiply stages to the matrix.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       chroma_site;
  } pmul_t;

  // Per-standard matrix coefficients, 8-bit fixed point.
  typedef struct packed {
    logic signed [8:0] yr;
    logic signed [8:0] yg;
    logic signed [8:0] yb;
    logic signed [8:0] ur;
    logic signed [8:0] ug;
    logic signed [8:0] vg;
    logic signed [8:0] vb;
  } coef_t;

  localparam coef_t COEF_709 = '{
    yr: 9'sd47,  yg: 9'sd157, yb: 9'sd16,
    ur: -9'sd26, ug: -9'sd87, vg: -9'sd102, vb: -9'sd10
  };

  localparam coef_t COEF_601 = '{
    yr: 9'sd66,  yg: 9'sd129, yb: 9'sd25,
    ur: -9'sd38, ug: -9'sd74, vg: -9'sd94, vb: -9'sd18
  };

  // Shared by both standards: blue weight of Cb and red weight of Cr.
  localparam logic signed [8:0] C_MAIN = 9'sd112;

  localparam logic signed [10:0] Y_OFFSET = 11'sd16;
  localparam logic signed [10:0] C_OFFSET = 11'sd128;

  function automatic coef_t coef_sel(input logic hd);
    coef_t c;
    c = hd ? COEF_709 : COEF_601;
    return c;
  endfunction

  // Signed coefficient times unsigned byte; the product magnitude stays
  // below 2^16, so 17 signed bits hold it.
  function automatic logic signed [16:0] mul_coef(input logic signed [8:0] c,
                                                  input logic [7:0] v);
    logic signed [16:0] cs;
    logic signed [16:0] vs;
    cs = 17'(c);
    vs = $signed({9'b0, v});
    return cs * vs;
  endfunction

  // Add half an LSB, floor-shift by 8, add the offset and saturate to a byte.
  function automatic logic [7:0] rnd_clamp(input logic signed [17:0] sum,
                                           input logic signed [10:0] offset);
    logic signed [17:0] t;
    logic signed [9:0]  sh;
    logic signed [10:0] v;
    logic [7:0]         res;
    t  = sum + 18'sd128;
    sh = t[17:8];
    v  = 11'(sh) + offset;
    if (v < 11'sd0) begin
      res = 8'd0;
    end else if (v > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### src/bpy_premul.sv
// ----------------------------------------------------------------------------
// bpy_premul
// Two pipeline stages: channel times alpha, then an exact divide by 255.
// ----------------------------------------------------------------------------
`default_nettype none

module bpy_premul (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire bpy_pkg::in_t  in_data,
  output logic               pm_valid,
  output bpy_pkg::pmul_t     pm_data
);

  logic        s1_valid_r;
  logic [15:0] s1_b_r;
  logic [15:0] s1_g_r;
  logic [15:0] s1_r_r;
  logic        s1_site_r;

  logic           s2_valid_r;
  bpy_pkg::pmul_t s2_data_r;
  bpy_pkg::pmul_t s2_data_nxt;

  // Floor of x/255 for x up to 255*255: (x + (x >> 8) + 1) >> 8 is exact
  // over that range, and the sum never leaves 16 bits.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] s;
    s = x + {8'd0, x[15:8]} + 16'd1;
    return s[15:8];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_b_r    <= 16'(in_data.blue)  * 16'(in_data.alpha);
    s1_g_r    <= 16'(in_data.green) * 16'(in_data.alpha);
    s1_r_r    <= 16'(in_data.red)   * 16'(in_data.alpha);
    s1_site_r <= in_data.chroma_site;
    s2_data_r <= s2_data_nxt;
  end

  always_comb begin
    s2_data_nxt.blue        = div255(s1_b_r);
    s2_data_nxt.green       = div255(s1_g_r);
    s2_data_nxt.red         = div255(s1_r_r);
    s2_data_nxt.chroma_site = s1_site_r;
  end

  assign pm_valid = s2_valid_r;
  assign pm_data  = s2_data_r;

endmodule

`default_nettype wire

### src/bpy_matrix.sv
// ----------------------------------------------------------------------------
// bpy_matrix
// Two pipeline stages: nine coefficient products, then the three sums with
// rounding, offset and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module bpy_matrix (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           hd_mode,
  input  wire logic           pm_valid,
  input  wire bpy_pkg::pmul_t pm_data,
  output logic                res_valid,
  output bpy_pkg::out_t       res_data
);

  bpy_pkg::coef_t coef;

  logic               s3_valid_r;
  logic               s3_site_r;
  logic signed [16:0] s3_yr_r, s3_yg_r, s3_yb_r;
  logic signed [16:0] s3_ur_r, s3_ug_r, s3_ub_r;
  logic signed [16:0] s3_vr_r, s3_vg_r, s3_vb_r;

  logic signed [17:0] y_sum, u_sum, v_sum;

  logic          s4_valid_r;
  bpy_pkg::out_t s4_data_r;
  bpy_pkg::out_t s4_data_nxt;

  // Change hd_mode only while the pipeline is empty (the block does not enforce it); it is used directly.
  assign coef = bpy_pkg::coef_sel(hd_mode);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= pm_valid;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_site_r <= pm_data.chroma_site;
    s3_yr_r   <= bpy_pkg::mul_coef(coef.yr, pm_data.red);
    s3_yg_r   <= bpy_pkg::mul_coef(coef.yg, pm_data.green);
    s3_yb_r   <= bpy_pkg::mul_coef(coef.yb, pm_data.blue);
    s3_ur_r   <= bpy_pkg::mul_coef(coef.ur, pm_data.red);
    s3_ug_r   <= bpy_pkg::mul_coef(coef.ug, pm_data.green);
    s3_ub_r   <= bpy_pkg::mul_coef(bpy_pkg::C_MAIN, pm_data.blue);
    s3_vr_r   <= bpy_pkg::mul_coef(bpy_pkg::C_MAIN, pm_data.red);
    s3_vg_r   <= bpy_pkg::mul_coef(coef.vg, pm_data.green);
    s3_vb_r   <= bpy_pkg::mul_coef(coef.vb, pm_data.blue);
    s4_data_r <= s4_data_nxt;
  end

  assign y_sum = 18'(s3_yr_r) + 18'(s3_yg_r) + 18'(s3_yb_r);
  assign u_sum = 18'(s3_ur_r) + 18'(s3_ug_r) + 18'(s3_ub_r);
  assign v_sum = 18'(s3_vr_r) + 18'(s3_vg_r) + 18'(s3_vb_r);

  always_comb begin
    s4_data_nxt.luma         = bpy_pkg::rnd_clamp(y_sum, bpy_pkg::Y_OFFSET);
    s4_data_nxt.chroma_valid = s3_site_r;
    // Pixels off a chroma site report zero chroma.
    if (s3_site_r) begin
      s4_data_nxt.cb = bpy_pkg::rnd_clamp(u_sum, bpy_pkg::C_OFFSET);
      s4_data_nxt.cr = bpy_pkg::rnd_clamp(v_sum, bpy_pkg::C_OFFSET);
    end else begin
      s4_data_nxt.cb = 8'd0;
      s4_data_nxt.cr = 8'd0;
    end
  end

  assign res_valid = s4_valid_r;
  assign res_data  = s4_data_r;

endmodule

`default_nettype wire

### src/bgra_premultiply_to_ycbcr.sv
// ----------------------------------------------------------------------------
// bgra_premultiply_to_ycbcr
// Premultiplies a BGRA pixel by its alpha and converts it to limited-range
// Y, Cb and Cr with BT.601 or BT.709 coefficients.
//
//   channel  direction  handshake          payload
//   in_      request    start, busy        in_data   (bpy_pkg::in_t)
//   out_     result     out_valid strobe   out_data  (bpy_pkg::out_t)
//   cfg_     write      cfg_we             cfg_wdata (hd_mode)
//
// One request is taken every cycle; busy is always low.
// Each request passes through the four pipeline stages: multiply,
// divide by 255, coefficient multiply, sum/clamp.
// Reset clears the stage valid bits and selects BT.601.
// The receiver cannot stall, so results are strobed for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module bgra_premultiply_to_ycbcr (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire bpy_pkg::in_t in_data,
  output logic              out_valid,
  output bpy_pkg::out_t     out_data,
  input  wire logic         cfg_we,
  input  wire logic         cfg_wdata
);

  logic           hd_mode_r;
  logic           pm_valid;
  bpy_pkg::pmul_t pm_data;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hd_mode_r <= 1'b0;
    end else if (cfg_we) begin
      hd_mode_r <= cfg_wdata;
    end
  end

  bpy_premul u_premul (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start & ~busy),
    .in_data  (in_data),
    .pm_valid (pm_valid),
    .pm_data  (pm_data)
  );

  bpy_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .hd_mode   (hd_mode_r),
    .pm_valid  (pm_valid),
    .pm_data   (pm_data),
    .res_valid (out_valid),
    .res_data  (out_data)
  );

  // A result always comes from a matching request taken earlier.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 4))
    else $error("result without a matching request");

  // Chroma validity follows the chroma site of the same request.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.chroma_valid == $past(in_data.chroma_site, 4)))
    else $error("chroma_valid does not match the request");

  // Off a chroma site the chroma fields are zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.chroma_valid) |-> (out_data.cb == 8'd0 && out_data.cr == 8'd0))
    else $error("chroma not zero off a chroma site");

  // A fully transparent pixel is black: Y at 16, chroma at mid scale.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_data.alpha, 4) == 8'd0) |->
      (out_data.luma == 8'd16 &&
       (!out_data.chroma_valid || (out_data.cb == 8'd128 && out_data.cr == 8'd128))))
    else $error("transparent pixel not converted to black");

endmodule

`default_nettype wire
